// File: src/slpm_pkg.sv
package slpm_pkg;

  localparam int IDX_W   = 6;
  localparam int COEF_W  = 16;
  localparam int VAL_W   = 17;
  localparam int PROD_W  = COEF_W + VAL_W;
  localparam int ACC_W   = 38;
  localparam int PRED_W  = 26;
  localparam int FRAC_W  = 12;
  localparam int NCOMP   = 3;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_LOAD   = 2'd1,
    OP_SAMPLE = 2'd2
  } op_t;

  typedef logic [NCOMP-1:0][VAL_W-1:0] vals_t;

  typedef struct packed {
    logic                     hit;
    logic                     last;
    logic signed [COEF_W-1:0] weight;
    vals_t                    vals;
  } sample_t;

endpackage

// File: src/sparse_linear_predictor_mac.sv
// Sparse linear pixel predictor, multiply-accumulate core.
// Input stream: tuser carries the operation (clear mask, load mask slot,
// regressor sample), tdata the slot position, Q12 weight and the three
// colour components, tlast the final regressor of a pixel.
// Output stream: one word per pixel, the three predictions (sum / 4096,
// truncated toward zero), sent on the sample marked tlast.
// Clear and load take effect at the edge that accepts them and never
// produce an output word. Samples are numbered from 0 within a pixel.
// A final sample passes the weight read register, product register, final sum
// register and output register to m_axis. Throughput: one input word every
// cycle while s_axis_tready is high; the weight memory write port is fed from
// the accepted word, its registered read port from the sample position.
// Reset empties the mask, zeroes the sample position and accumulators and
// drops any word in flight; weight memory contents are kept.
// When the receiver stalls, the output word holds, the next finished pixel
// waits in the final sum register and samples keep flowing until a third
// finished pixel sits in the product register with a sample queued behind
// it; then s_axis_tready drops until m_axis_tready returns.
module sparse_linear_predictor_mac #(
  parameter int MAX_REGRESSORS = 63
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // regressor_index, coefficient, value_first, value_second, value_third, pad
  input  logic [79:0] s_axis_tdata,
  // operation
  input  logic [1:0]  s_axis_tuser,
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // pred_first, pred_second, pred_third, pad
  output logic [79:0] m_axis_tdata
);
  import slpm_pkg::*;

  logic                         smp_valid;
  logic                         smp_ready;
  sample_t                      smp;
  vals_t                        vals;
  logic [NCOMP-1:0][PRED_W-1:0] res;

  assign vals[0] = s_axis_tdata[38:22];
  assign vals[1] = s_axis_tdata[55:39];
  assign vals[2] = s_axis_tdata[72:56];

  slpm_mask #(
    .MAX_REGRESSORS(MAX_REGRESSORS)
  ) u_mask (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .op        (op_t'(s_axis_tuser)),
    .idx       (s_axis_tdata[5:0]),
    .coef      ($signed(s_axis_tdata[21:6])),
    .vals      (vals),
    .last      (s_axis_tlast),
    .smp_valid (smp_valid),
    .smp       (smp),
    .smp_ready (smp_ready)
  );

  slpm_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .smp_valid (smp_valid),
    .smp       (smp),
    .smp_ready (smp_ready),
    .res_valid (m_axis_tvalid),
    .res       (res),
    .res_ready (m_axis_tready)
  );

  assign m_axis_tdata = {2'b00, res[2], res[1], res[0]};

endmodule

// File: src/slpm_mask.sv
module slpm_mask #(
  parameter int MAX_REGRESSORS = 63
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  slpm_pkg::op_t                     op,
  input  logic [slpm_pkg::IDX_W-1:0]        idx,
  input  logic signed [slpm_pkg::COEF_W-1:0] coef,
  input  slpm_pkg::vals_t                   vals,
  input  logic                              last,
  output logic                              smp_valid,
  output slpm_pkg::sample_t                 smp,
  input  logic                              smp_ready
);
  import slpm_pkg::*;

  localparam int TAB_W = $clog2(MAX_REGRESSORS);
  localparam int CNT_W = $clog2(MAX_REGRESSORS + 1);
  localparam logic [IDX_W-1:0] MAX_IDX = IDX_W'(MAX_REGRESSORS);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_REGRESSORS);

  logic [MAX_REGRESSORS-1:0] claimed;
  logic signed [COEF_W-1:0]  weight_mem [MAX_REGRESSORS];
  logic signed [COEF_W-1:0]  weight_q;
  logic [CNT_W-1:0]          pos;
  logic [CNT_W-1:0]          pos_next;
  logic                      hit_q;
  logic                      last_q;
  vals_t                     vals_q;

  logic             accept;
  logic             do_clear;
  logic             do_sample;
  logic             load_ok;
  logic             pos_in_range;
  logic [TAB_W-1:0] wr_addr;
  logic [TAB_W-1:0] rd_addr;

  assign in_ready = !smp_valid || smp_ready;
  assign accept   = in_valid && in_ready;
  assign wr_addr  = idx[TAB_W-1:0];
  assign rd_addr  = pos[TAB_W-1:0];

  always_comb begin
    do_clear     = 1'b0;
    do_sample    = 1'b0;
    load_ok      = 1'b0;
    pos_in_range = pos < MAX_CNT;
    pos_next     = pos;
    case (op)
      OP_CLEAR: begin
        do_clear = accept;
      end
      OP_LOAD: begin
        load_ok = accept && (idx < MAX_IDX) && !claimed[wr_addr];
      end
      OP_SAMPLE: begin
        do_sample = accept;
        if (last) begin
          pos_next = '0;
        end else if (pos_in_range) begin
          pos_next = pos + CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      claimed   <= '0;
      pos       <= '0;
      smp_valid <= 1'b0;
    end else begin
      if (do_clear) begin
        claimed <= '0;
      end else if (load_ok) begin
        claimed[wr_addr] <= 1'b1;
      end
      if (do_sample) begin
        pos <= pos_next;
      end
      if (in_ready) begin
        smp_valid <= do_sample;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_sample) begin
      hit_q  <= pos_in_range && claimed[rd_addr];
      last_q <= last;
      vals_q <= vals;
    end
  end

  always_ff @(posedge clk) begin
    if (load_ok) begin
      weight_mem[wr_addr] <= coef;
    end
    if (do_sample && pos_in_range) begin
      weight_q <= weight_mem[rd_addr];
    end
  end

  always_comb begin
    smp.hit    = hit_q;
    smp.last   = last_q;
    smp.weight = weight_q;
    smp.vals   = vals_q;
  end

endmodule

// File: src/slpm_mac.sv
module slpm_mac (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        smp_valid,
  input  slpm_pkg::sample_t                           smp,
  output logic                                        smp_ready,
  output logic                                        res_valid,
  output logic [slpm_pkg::NCOMP-1:0][slpm_pkg::PRED_W-1:0] res,
  input  logic                                        res_ready
);
  import slpm_pkg::*;

  logic                     p_valid;
  logic                     p_last;
  logic signed [PROD_W-1:0] prod [NCOMP];
  logic signed [PROD_W-1:0] prod_next [NCOMP];

  logic signed [ACC_W-1:0]  acc [NCOMP];
  logic signed [ACC_W-1:0]  acc_sum [NCOMP];

  logic                     f_valid;
  logic signed [ACC_W-1:0]  fsum [NCOMP];
  logic signed [ACC_W-1:0]  fsum_adj [NCOMP];
  logic [NCOMP-1:0][PRED_W-1:0] res_next;

  logic out_free;
  logic f_free;
  logic f_go;
  logic p_go;
  logic p_free;

  assign out_free  = !res_valid || res_ready;
  assign f_go      = f_valid && out_free;
  assign f_free    = !f_valid || out_free;
  assign p_go      = p_valid && (!p_last || f_free);
  assign p_free    = !p_valid || p_go;
  assign smp_ready = p_free;

  always_comb begin
    for (int k = 0; k < NCOMP; k++) begin
      if (smp.hit) begin
        prod_next[k] = smp.weight * $signed(smp.vals[k]);
      end else begin
        prod_next[k] = '0;
      end
      acc_sum[k] = acc[k] + ACC_W'(prod[k]);
      if (fsum[k][ACC_W-1]) begin
        fsum_adj[k] = fsum[k] + ACC_W'((1 << FRAC_W) - 1);
      end else begin
        fsum_adj[k] = fsum[k];
      end
      res_next[k] = PRED_W'(fsum_adj[k] >>> FRAC_W);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid   <= 1'b0;
      f_valid   <= 1'b0;
      res_valid <= 1'b0;
      for (int k = 0; k < NCOMP; k++) begin
        acc[k] <= '0;
      end
    end else begin
      if (p_free) begin
        p_valid <= smp_valid;
      end
      if (f_free) begin
        f_valid <= p_go && p_last;
      end
      if (out_free) begin
        res_valid <= f_valid;
      end
      if (p_go) begin
        for (int k = 0; k < NCOMP; k++) begin
          acc[k] <= p_last ? '0 : acc_sum[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (p_free && smp_valid) begin
      p_last <= smp.last;
      for (int k = 0; k < NCOMP; k++) begin
        prod[k] <= prod_next[k];
      end
    end
    if (p_go && p_last) begin
      for (int k = 0; k < NCOMP; k++) begin
        fsum[k] <= acc_sum[k];
      end
    end
    if (f_go) begin
      res <= res_next;
    end
  end

endmodule
